FILE: src/aled_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aled_pkg
// Shared types, constants and helper functions for the addressable LED
// chain driver.
// ----------------------------------------------------------------------------
package aled_pkg;

    localparam int PIXELS = 64;
    localparam int PIX_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    localparam int PIXEL_W  = 24;
    localparam int BIT_W    = 5;
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(PIXEL_W - 1);
    localparam logic [PIX_W-1:0] LAST_PIXEL = PIX_W'(PIXELS - 1);

    localparam int IDLE_W = 16;
    localparam logic [IDLE_W-1:0] IDLE_SAT = '1;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH_TICKS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW_TICKS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH_TICKS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW_TICKS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_TICKS       = 3'd5;

    localparam logic [7:0]  RST_BRIGHTNESS      = 8'd255;
    localparam logic [7:0]  RST_ONE_HIGH_TICKS  = 8'd8;
    localparam logic [7:0]  RST_ONE_LOW_TICKS   = 8'd4;
    localparam logic [7:0]  RST_ZERO_HIGH_TICKS = 8'd4;
    localparam logic [7:0]  RST_ZERO_LOW_TICKS  = 8'd8;
    localparam logic [15:0] RST_GAP_TICKS       = 16'd500;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SEND = 1'b1
    } state_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] pixel_index;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } in_t;

    typedef struct packed {
        logic data_pin;
        logic frame_busy;
    } out_t;

    typedef struct packed {
        logic [7:0]  brightness;
        logic [7:0]  one_high_ticks;
        logic [7:0]  one_low_ticks;
        logic [7:0]  zero_high_ticks;
        logic [7:0]  zero_low_ticks;
        logic [15:0] gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic               wr_en;
        logic               clr;
        logic [PIX_W-1:0]   addr;
        logic [PIXEL_W-1:0] data;
    } store_wr_t;

    // Tick count of one phase; a programmed zero counts as one tick.
    function automatic logic [7:0] phase_len(input cfg_t cfg, input logic one,
                                             input logic high);
        logic [7:0] raw;
        if (high)
            raw = one ? cfg.one_high_ticks : cfg.zero_high_ticks;
        else
            raw = one ? cfg.one_low_ticks : cfg.zero_low_ticks;
        return (raw == 8'd0) ? 8'd1 : raw;
    endfunction

    // Scale each color of a G,R,B word by brightness, (c*b)>>8.
    function automatic logic [PIXEL_W-1:0] scale_pixel(input logic [PIXEL_W-1:0] p,
                                                       input logic [7:0] b);
        logic [15:0] g_prod;
        logic [15:0] r_prod;
        logic [15:0] b_prod;
        g_prod = 16'(p[23:16]) * 16'(b);
        r_prod = 16'(p[15:8]) * 16'(b);
        b_prod = 16'(p[7:0]) * 16'(b);
        return {g_prod[15:8], r_prod[15:8], b_prod[15:8]};
    endfunction

endpackage
`default_nettype wire

FILE: src/aled_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aled_store
// Pixel memory with per-entry valid bits and a registered prefetch port
// that forwards the write or clear of the same cycle.
// ----------------------------------------------------------------------------
module aled_store (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire aled_pkg::store_wr_t         wr,
    input  wire logic [aled_pkg::PIX_W-1:0]  rd_addr,
    output logic [aled_pkg::PIXEL_W-1:0]     pixel
);
    import aled_pkg::*;

    logic [PIXEL_W-1:0] pixel_mem [PIXELS];
    logic [PIXEL_W-1:0] rd_data_reg;
    logic [PIXELS-1:0]  valid_reg;
    logic [PIXELS-1:0]  valid_next;
    logic               fwd_sel_reg;
    logic               fwd_sel_next;
    logic [PIXEL_W-1:0] fwd_data_reg;
    logic [PIXEL_W-1:0] fwd_data_next;

    always_ff @(posedge clk) begin
        if (wr.wr_en)
            pixel_mem[wr.addr] <= wr.data;
        rd_data_reg <= pixel_mem[rd_addr];
    end

    // Drop all valid bits on clear; set one on write.
    always_comb begin
        valid_next = valid_reg;
        if (wr.clr)
            valid_next = '0;
        else if (wr.wr_en)
            valid_next[wr.addr] = 1'b1;
    end

    // Bypass the memory when the entry is being written, cleared or never set.
    always_comb begin
        fwd_sel_next  = 1'b0;
        fwd_data_next = '0;
        if (wr.wr_en && (wr.addr == rd_addr)) begin
            fwd_sel_next  = 1'b1;
            fwd_data_next = wr.data;
        end else if (wr.clr || !valid_reg[rd_addr]) begin
            fwd_sel_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg    <= '0;
            fwd_sel_reg  <= 1'b1;
            fwd_data_reg <= '0;
        end else begin
            valid_reg    <= valid_next;
            fwd_sel_reg  <= fwd_sel_next;
            fwd_data_reg <= fwd_data_next;
        end
    end

    assign pixel = fwd_sel_reg ? fwd_data_reg : rd_data_reg;

endmodule
`default_nettype wire

FILE: src/aled_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aled_engine
// Frame sequencer and bit timing: refresh request, gap counter, pixel and
// bit counters, phase timer and shifter. One item per enabled cycle.
// ----------------------------------------------------------------------------
module aled_engine (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         proc_en,
    input  wire aled_pkg::in_t                item,
    input  wire aled_pkg::cfg_t               cfg,
    input  wire logic [aled_pkg::PIXEL_W-1:0] pixel,
    output aled_pkg::store_wr_t               wr,
    output logic [aled_pkg::PIX_W-1:0]        fetch_addr,
    output aled_pkg::out_t                    result
);
    import aled_pkg::*;

    state_t             state_reg, state_next;
    logic               pending_reg, pending_next;
    logic [PIX_W-1:0]   pc_reg, pc_next;
    logic [BIT_W-1:0]   bitcnt_reg, bitcnt_next;
    logic               high_reg, high_next;
    logic [7:0]         pt_reg, pt_next;
    logic [IDLE_W-1:0]  idle_reg, idle_next;
    logic [PIXEL_W-1:0] shift_reg, shift_next;
    logic               drive_reg, drive_next;

    logic               idx_ok;
    logic               is_tick;
    logic               start;
    logic               running;
    logic [PIXEL_W-1:0] loaded;
    logic               cur_high;
    logic [7:0]         cur_pt;
    logic [PIXEL_W-1:0] cur_shift;
    logic [BIT_W-1:0]   cur_bitcnt;
    logic [PIX_W-1:0]   cur_pc;
    logic [7:0]         pt_dec;
    logic               phase_done;
    logic               last;
    logic               frame_end;

    assign idx_ok = (32'(item.pixel_index) < 32'(PIXELS));

    assign wr.wr_en = proc_en && (item.action == ACT_WRITE) && idx_ok;
    assign wr.clr   = proc_en && (item.action == ACT_CLEAR);
    assign wr.addr  = PIX_W'(item.pixel_index);
    assign wr.data  = {item.green_level, item.red_level, item.blue_level};

    // Tick decode: a starting frame loads pixel zero into the same tick.
    always_comb begin
        is_tick    = proc_en && (item.action == ACT_TICK);
        start      = is_tick && (state_reg == ST_IDLE) && pending_reg
                     && (idle_reg >= cfg.gap_ticks);
        running    = is_tick && ((state_reg == ST_SEND) || start);
        loaded     = scale_pixel(pixel, cfg.brightness);
        cur_high   = start ? 1'b1 : high_reg;
        cur_pt     = start ? phase_len(cfg, loaded[PIXEL_W-1], 1'b1) : pt_reg;
        cur_shift  = start ? loaded : shift_reg;
        cur_bitcnt = start ? LAST_BIT : bitcnt_reg;
        cur_pc     = start ? '0 : pc_reg;
        pt_dec     = cur_pt - 8'd1;
        phase_done = (pt_dec == 8'd0);
        last       = phase_done && !cur_high && (cur_bitcnt == '0)
                     && (cur_pc == LAST_PIXEL);
        frame_end  = running && last;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (start) state_next = ST_SEND;
            ST_SEND: if (frame_end) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        pending_next = pending_reg;
        pc_next      = pc_reg;
        bitcnt_next  = bitcnt_reg;
        high_next    = high_reg;
        pt_next      = pt_reg;
        idle_next    = idle_reg;
        shift_next   = shift_reg;
        drive_next   = drive_reg;
        if (proc_en) begin
            case (item.action)
                ACT_WRITE: begin
                    if (idx_ok)
                        pending_next = 1'b1;
                end
                ACT_CLEAR: begin
                    pending_next = 1'b1;
                end
                ACT_TICK: begin
                    if (!running) begin
                        if (idle_reg != IDLE_SAT)
                            idle_next = idle_reg + IDLE_W'(1);
                        drive_next = 1'b0;
                    end else begin
                        if (start)
                            pending_next = 1'b0;
                        drive_next  = cur_high;
                        shift_next  = cur_shift;
                        bitcnt_next = cur_bitcnt;
                        pc_next     = cur_pc;
                        high_next   = cur_high;
                        pt_next     = pt_dec;
                        if (phase_done) begin
                            if (cur_high) begin
                                high_next = 1'b0;
                                pt_next   = phase_len(cfg, cur_shift[PIXEL_W-1], 1'b0);
                            end else if (cur_bitcnt != '0) begin
                                bitcnt_next = cur_bitcnt - BIT_W'(1);
                                shift_next  = {cur_shift[PIXEL_W-2:0], 1'b0};
                                high_next   = 1'b1;
                                pt_next     = phase_len(cfg, cur_shift[PIXEL_W-2], 1'b1);
                            end else if (last) begin
                                pc_next     = '0;
                                bitcnt_next = '0;
                                pt_next     = 8'd0;
                                high_next   = 1'b0;
                                idle_next   = '0;
                            end else begin
                                pc_next     = cur_pc + PIX_W'(1);
                                shift_next  = loaded;
                                bitcnt_next = LAST_BIT;
                                high_next   = 1'b1;
                                pt_next     = phase_len(cfg, loaded[PIXEL_W-1], 1'b1);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Prefetch the pixel the next load will need.
    assign fetch_addr = (state_next == ST_SEND) ? (pc_next + PIX_W'(1)) : '0;

    assign result.data_pin   = drive_next;
    assign result.frame_busy = (state_next == ST_SEND) || pending_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
            pc_reg      <= '0;
            bitcnt_reg  <= '0;
            high_reg    <= 1'b0;
            pt_reg      <= 8'd0;
            idle_reg    <= IDLE_SAT;
            shift_reg   <= '0;
            drive_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            pc_reg      <= pc_next;
            bitcnt_reg  <= bitcnt_next;
            high_reg    <= high_next;
            pt_reg      <= pt_next;
            idle_reg    <= idle_next;
            shift_reg   <= shift_next;
            drive_reg   <= drive_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((bitcnt_reg == '0) && (pt_reg == 8'd0) && !high_reg))
        else $error("idle with live bit timing state");

    a_phase_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND) |-> (pt_reg != 8'd0))
        else $error("sending with empty phase timer");

    a_pin_low_idle: assert property (@(posedge clk) disable iff (!rst_n)
        drive_reg |-> (state_reg == ST_SEND))
        else $error("data pin high outside a frame");
`endif

endmodule
`default_nettype wire

FILE: src/addressable_led_chain_driver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// addressable_led_chain_driver
// Single-wire RGB LED chain driver: stores a frame of pixels and sends it
// with programmable bit timing after a refresh request and idle gap.
// ----------------------------------------------------------------------------
// Flow: an accepted beat sits in the input register, and its sequencer step
//   lands in the output register once the output stage is free or draining,
//   where the result beat waits until out_ready takes it.
// Throughput: one beat per cycle while the output drains; the pixel memory
//   read is prefetched with forwarding, so every beat is one sequencer step.
// Reset: asynchronous, active low; clears all control state and every pixel
//   valid bit, so the frame store reads as zero right away.
// ----------------------------------------------------------------------------
module addressable_led_chain_driver (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire aled_pkg::in_t                     in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output aled_pkg::out_t                         out_data,
    input  wire logic                              cfg_wr_en,
    input  wire logic [aled_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [aled_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import aled_pkg::*;

    // Input stage: one beat waiting for the sequencer.
    in_t    in_reg;
    logic   in_valid_reg, in_valid_next;
    // Output stage: one finished result beat.
    out_t   out_reg;
    logic   out_valid_reg, out_valid_next;
    // Configuration registers.
    cfg_t   cfg_reg, cfg_next;

    logic                advance;
    logic                proc_en;
    logic                in_fire;
    store_wr_t           wr;
    logic [PIX_W-1:0]    fetch_addr;
    logic [PIXEL_W-1:0]  pixel;
    out_t                result;

    // The sequencer steps whenever the output stage is free or draining.
    assign advance  = !out_valid_reg || out_ready;
    assign proc_en  = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_fire)
            in_valid_next = 1'b1;
        else if (proc_en)
            in_valid_next = 1'b0;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (proc_en)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Register writes; indexes beyond the list are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_BRIGHTNESS:      cfg_next.brightness      = cfg_data[7:0];
                REG_ONE_HIGH_TICKS:  cfg_next.one_high_ticks  = cfg_data[7:0];
                REG_ONE_LOW_TICKS:   cfg_next.one_low_ticks   = cfg_data[7:0];
                REG_ZERO_HIGH_TICKS: cfg_next.zero_high_ticks = cfg_data[7:0];
                REG_ZERO_LOW_TICKS:  cfg_next.zero_low_ticks  = cfg_data[7:0];
                REG_GAP_TICKS:       cfg_next.gap_ticks       = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            cfg_reg.brightness      <= RST_BRIGHTNESS;
            cfg_reg.one_high_ticks  <= RST_ONE_HIGH_TICKS;
            cfg_reg.one_low_ticks   <= RST_ONE_LOW_TICKS;
            cfg_reg.zero_high_ticks <= RST_ZERO_HIGH_TICKS;
            cfg_reg.zero_low_ticks  <= RST_ZERO_LOW_TICKS;
            cfg_reg.gap_ticks       <= RST_GAP_TICKS;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    // Payload registers: load on accept, hold otherwise.
    always_ff @(posedge clk) begin
        if (in_fire)
            in_reg <= in_data;
        if (proc_en)
            out_reg <= result;
    end

    // Frame store: written by pixel beats, read ahead for the next load.
    aled_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (fetch_addr),
        .pixel   (pixel)
    );

    // Sequencer: refresh, gap, pixel/bit counters and phase timing.
    aled_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .proc_en    (proc_en),
        .item       (in_reg),
        .cfg        (cfg_reg),
        .pixel      (pixel),
        .wr         (wr),
        .fetch_addr (fetch_addr),
        .result     (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire
